/* rtl/lsw_pkg.sv */
// lsw_pkg: shared codes and constants for the lcd shadow write filter
// used by lsw_shadow_ram and lcd_shadow_write_filter_core; no dependencies
package lsw_pkg;

    // item kinds on the cmd field
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_PUTC  = 2'd2,
        CMD_ENDL  = 2'd3
    } cmd_t;

    // register select values on the display bus
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // display controller bytes
    localparam logic [7:0] CLEAR_INSTR = 8'h01;
    localparam logic [7:0] SET_ADDR    = 8'h80;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;

    // cursor layout: bit 6 line, bits 5..0 column
    localparam int         CURSOR_W = 7;
    localparam logic [6:0] LINE_BIT = 7'h40;

    // words returned per item at most
    localparam int MAX_RESULTS = 40;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // default screen width
    localparam int COLUMNS_DEFAULT = 20;

endpackage

/* rtl/lsw_shadow_ram.sv */
// lsw_shadow_ram: shadow copy of the screen, one write and one read port
// read data registered; uses lsw_pkg
module lsw_shadow_ram #(
    parameter int DEPTH = 2 * lsw_pkg::COLUMNS_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    import lsw_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lcd_shadow_write_filter_core.sv */
// lcd_shadow_write_filter_core: character display front end with shadow screen
// depends on lsw_pkg and lsw_shadow_ram
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------
//   in      | in_valid / in_stall     | cmd, char_code, column, line
//   out     | out_valid / out_stall   | reg_select, bus_byte, last
//
// goto only moves the cursor; put character skips an unchanged cell and rewrites a changed one;
// end of line walks unchanged and rewritten cells the same way; clear also sweeps the shadow.
// every character step reads and compares a shadow ram cell, and writes it back when it differs.
// after reset a clearing pass fills the shadow with spaces,
// with in_stall high. a stalled output holds the walk when a word is due;
// one word may wait in the output register while the next item is taken.
module lcd_shadow_write_filter_core #(
    parameter int COLUMNS = lsw_pkg::COLUMNS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [7:0]          char_code,
    input  logic [5:0]          column,
    input  logic                line,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                reg_select,
    output logic [7:0]          bus_byte,
    output logic                last
);
    import lsw_pkg::*;

    localparam int              DEPTH     = 2 * COLUMNS;
    localparam int              AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]   ROW1_BASE = AW'(COLUMNS);
    localparam logic [AW-1:0]   SWEEP_END = AW'(DEPTH - 1);
    localparam logic [6:0]      COL_LIMIT = 7'(COLUMNS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_LOOK,
        ST_DATA,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [CURSOR_W-1:0]    logical_reg;
    logic [CURSOR_W-1:0]    display_reg;
    logic [AW-1:0]          sweep_reg;
    logic [AW-1:0]          idx_reg;
    logic [7:0]             char_reg;
    logic                   endl_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   pend_valid_reg;
    logic                   pend_rs_reg;
    logic [7:0]             pend_byte_reg;
    logic                   out_valid_reg;
    logic                   out_rs_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [7:0]             ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [7:0]             ram_rdata;

    logic [CURSOR_W-1:0]    logical_inc;
    logic [AW-1:0]          cur_idx;
    logic                   col_ok;
    logic                   can_push;
    logic                   may_emit;
    logic                   room;
    logic                   look_differ;
    logic                   need_addr;
    logic                   look_go;
    logic                   data_go;
    logic                   walk_on;
    logic                   in_take;
    cmd_t                   in_cmd;

    // cursor arithmetic and shadow index
    assign logical_inc = logical_reg + 7'd1;
    assign cur_idx     = (logical_reg[6] ? ROW1_BASE : '0) + AW'(logical_reg[5:0]);
    assign col_ok      = {1'b0, logical_reg[5:0]} < COL_LIMIT;
    assign walk_on     = endl_reg && ({1'b0, logical_inc[5:0]} < COL_LIMIT);

    // output side room and result cap
    assign can_push    = !out_valid_reg || !out_stall;
    assign may_emit    = cnt_reg < CNT_MAX;
    assign room        = !pend_valid_reg || can_push;
    assign look_differ = ram_rdata != char_reg;
    assign need_addr   = logical_reg != display_reg;
    assign look_go     = !(look_differ && need_addr && may_emit && !room);
    assign data_go     = !(may_emit && !room);

    assign in_stall = state_reg != ST_IDLE;
    assign in_take  = in_valid && !in_stall;
    assign in_cmd   = cmd_t'(cmd);

    // shadow ram control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = char_reg;
        ram_re    = 1'b0;
        ram_raddr = idx_reg + AW'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = cur_idx;
                ram_re    = in_take && col_ok &&
                            (in_cmd == CMD_PUTC || in_cmd == CMD_ENDL);
            end
            ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = SPACE_CHAR;
            end
            ST_LOOK:
            begin
                ram_re = !look_differ && walk_on;
            end
            ST_DATA:
            begin
                ram_we = data_go;
                ram_re = data_go && walk_on;
            end
            ST_FIN:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    lsw_shadow_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer, pending word and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            logical_reg    <= '0;
            display_reg    <= '0;
            sweep_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        char_reg <= (in_cmd == CMD_PUTC) ? char_code : SPACE_CHAR;
                        endl_reg <= in_cmd == CMD_ENDL;
                        idx_reg  <= cur_idx;
                        cnt_reg  <= '0;
                        unique case (in_cmd)
                            CMD_CLEAR:
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_rs_reg    <= RS_INSTR;
                                pend_byte_reg  <= CLEAR_INSTR;
                                cnt_reg        <= CNT_W'(1);
                                logical_reg    <= '0;
                                display_reg    <= '0;
                                sweep_reg      <= '0;
                                state_reg      <= ST_CLR;
                            end
                            CMD_GOTO:
                            begin
                                logical_reg <= {line, column};
                            end
                            CMD_PUTC:
                            begin
                                if (col_ok)
                                begin
                                    state_reg <= ST_LOOK;
                                end
                            end
                            CMD_ENDL:
                            begin
                                if (col_ok)
                                begin
                                    state_reg <= ST_LOOK;
                                end
                                else if (!logical_reg[6])
                                begin
                                    logical_reg <= LINE_BIT;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CLR:
                begin
                    if (sweep_reg == SWEEP_END)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        sweep_reg <= sweep_reg + AW'(1);
                    end
                end
                ST_LOOK:
                begin
                    if (look_differ)
                    begin
                        if (look_go)
                        begin
                            // address word only when the display cursor is elsewhere
                            if (need_addr)
                            begin
                                display_reg <= logical_reg;
                                if (may_emit)
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        out_valid_reg <= 1'b1;
                                        out_rs_reg    <= pend_rs_reg;
                                        out_byte_reg  <= pend_byte_reg;
                                        out_last_reg  <= 1'b0;
                                    end
                                    pend_valid_reg <= 1'b1;
                                    pend_rs_reg    <= RS_INSTR;
                                    pend_byte_reg  <= SET_ADDR | {1'b0, logical_reg};
                                    cnt_reg        <= cnt_reg + CNT_W'(1);
                                end
                            end
                            state_reg <= ST_DATA;
                        end
                    end
                    else
                    begin
                        // cell already holds the character
                        logical_reg <= logical_inc;
                        if (walk_on)
                        begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                        else
                        begin
                            if (endl_reg && !logical_inc[6])
                            begin
                                logical_reg <= LINE_BIT;
                            end
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_DATA:
                begin
                    if (data_go)
                    begin
                        if (may_emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_rs_reg    <= pend_rs_reg;
                                out_byte_reg  <= pend_byte_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_rs_reg    <= RS_DATA;
                            pend_byte_reg  <= char_reg;
                            cnt_reg        <= cnt_reg + CNT_W'(1);
                        end
                        display_reg <= logical_inc;
                        logical_reg <= logical_inc;
                        if (walk_on)
                        begin
                            idx_reg   <= idx_reg + AW'(1);
                            state_reg <= ST_LOOK;
                        end
                        else
                        begin
                            if (endl_reg && !logical_inc[6])
                            begin
                                logical_reg <= LINE_BIT;
                            end
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN:
                begin
                    // flush the held word as the item's final word
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (can_push)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_rs_reg     <= pend_rs_reg;
                        out_byte_reg   <= pend_byte_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = out_rs_reg;
    assign bus_byte   = out_byte_reg;
    assign last       = out_last_reg;

    // no word is held back once the block takes items again
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending word left over at idle");

    // words per item never pass the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("result count beyond cap");

    // a data write always follows a compare of the same cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> ($past(state_reg) == ST_LOOK ||
                                    $past(state_reg) == ST_DATA))
        else $error("data step without a preceding compare");

    // the shadow is only walked below its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> ({1'b0, idx_reg} < (AW + 1)'(DEPTH)))
        else $error("shadow index out of range");

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for lcd_shadow_write_filter_core
// depends on lsw_pkg and the core rtl; holds its own shadow-screen predictor
// and checks every display word in order under several idle and stall mixes
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    localparam int COLS      = COLUMNS_DEFAULT;
    localparam int LIMIT     = 400000;
    localparam int TAIL      = 200;
    localparam int MAX_SHOWN = 10;

    // one word on the display bus
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       is_last;
    } lcd_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    cmd_t       cmd       = CMD_CLEAR;
    logic [7:0] char_code = 8'h00;
    logic [5:0] column    = 6'd0;
    logic       line      = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last;

    // predicted screen state
    logic [7:0]          shadow_cells [2*COLS];
    logic [CURSOR_W-1:0] write_cursor;
    logic [CURSOR_W-1:0] panel_cursor;

    lcd_word_t bus_words_due[$];
    lcd_word_t item_words[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int words_checked  = 0;
    int cycle_count    = 0;
    int kind_count [4] = '{0, 0, 0, 0};

    lcd_shadow_write_filter_core #(
        .COLUMNS (COLS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_code  (char_code),
        .column     (column),
        .line       (line),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, bus_words_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // append one word for the current item, dropping any beyond the cap
    task automatic queue_display_word(logic rs, logic [7:0] b);
        lcd_word_t w;
        w.rs      = rs;
        w.data    = b;
        w.is_last = 1'b0;
        if (item_words.size() < MAX_RESULTS)
            item_words.push_back(w);
    endtask

    // one character step: skipped past the line end, filtered when unchanged
    task automatic shadow_put(logic [7:0] ch);
        int idx;
        if (int'(write_cursor[5:0]) >= COLS)
            return;
        idx = int'(write_cursor[5:0]) + (write_cursor[6] ? COLS : 0);
        if (shadow_cells[idx] != ch)
        begin
            if (write_cursor != panel_cursor)
            begin
                queue_display_word(RS_INSTR, SET_ADDR + {1'b0, write_cursor});
                panel_cursor = write_cursor;
            end
            queue_display_word(RS_DATA, ch);
            panel_cursor      = panel_cursor + 1'b1;
            shadow_cells[idx] = ch;
        end
        write_cursor = write_cursor + 1'b1;
    endtask

    task automatic blank_shadow;
        foreach (shadow_cells[i])
            shadow_cells[i] = SPACE_CHAR;
        write_cursor = '0;
        panel_cursor = '0;
    endtask

    // work out the display words one accepted item causes
    task automatic predict_display_words(cmd_t c, logic [7:0] ch, logic [5:0] col,
                                         logic ln);
        item_words.delete();
        case (c)
            CMD_CLEAR:
            begin
                queue_display_word(RS_INSTR, CLEAR_INSTR);
                blank_shadow();
            end
            CMD_GOTO:
                write_cursor = {ln, col};
            CMD_PUTC:
                shadow_put(ch);
            default:
            begin
                while (int'(write_cursor[5:0]) < COLS)
                    shadow_put(SPACE_CHAR);
                if (!write_cursor[6])
                    write_cursor = LINE_BIT;
            end
        endcase
        if (item_words.size() > 0)
            item_words[item_words.size() - 1].is_last = 1'b1;
        foreach (item_words[i])
            bus_words_due.push_back(item_words[i]);
    endtask

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(cmd_t c, logic [7:0] ch, logic [5:0] col, logic ln);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        char_code <= ch;
        column    <= col;
        line      <= ln;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_display_words(c, ch, col, ln);
        kind_count[c]++;
    endtask

    // stop sending until every due word has come back
    task automatic hold_until_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (bus_words_due.size() != 0)
            @(posedge clk);
    endtask

    // check each accepted word against the oldest one due, and stall at random
    always @(posedge clk)
    begin : bus_checker
        lcd_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (bus_words_due.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("%0t: word with none due: rs %0b byte %02h last %0b",
                             $realtime, reg_select, bus_byte, last);
            end
            else
            begin
                want = bus_words_due.pop_front();
                if (reg_select !== want.rs || bus_byte !== want.data
                        || last !== want.is_last)
                begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                    begin
                        $display("%0t: mismatch: expected rs %0b byte %02h last %0b",
                                 $realtime, want.rs, want.data, want.is_last);
                        $display("    got rs %0b byte %02h last %0b",
                                 reg_select, bus_byte, last);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // clear, cursor moves to the extremes, puts past the line end
    task automatic test_clear_and_goto;
        send_item(CMD_CLEAR, 8'hff, 6'd63, 1'b1);
        send_item(CMD_GOTO, 8'haa, 6'd0, 1'b0);
        send_item(CMD_GOTO, 8'h00, 6'd63, 1'b1);
        send_item(CMD_PUTC, 8'h55, 6'd17, 1'b0);
        send_item(CMD_GOTO, 8'hff, 6'd63, 1'b0);
        send_item(CMD_PUTC, 8'h00, 6'd42, 1'b1);
        send_item(CMD_GOTO, 8'h12, 6'(COLS - 1), 1'b1);
        send_item(CMD_PUTC, 8'hff, 6'd0, 1'b0);
        send_item(CMD_PUTC, 8'h7e, 6'd5, 1'b1);
    endtask

    // unchanged cells are filtered, moved cursors need an address word
    task automatic test_put_filtering;
        send_item(CMD_GOTO, 8'h00, 6'd0, 1'b0);
        send_item(CMD_PUTC, 8'h48, 6'd63, 1'b1);
        send_item(CMD_PUTC, SPACE_CHAR, 6'd0, 1'b0);
        send_item(CMD_PUTC, 8'h69, 6'd0, 1'b0);
        send_item(CMD_GOTO, 8'hff, 6'd0, 1'b0);
        send_item(CMD_PUTC, 8'h48, 6'd1, 1'b0);
        send_item(CMD_PUTC, 8'h00, 6'd2, 1'b1);
        hold_until_drained();
        send_item(CMD_PUTC, 8'h80, 6'd3, 1'b0);
    endtask

    // padding to the line end on both lines and from beyond the width
    task automatic test_end_of_line;
        send_item(CMD_GOTO, 8'h00, 6'd0, 1'b0);
        send_item(CMD_ENDL, 8'hff, 6'd63, 1'b1);
        send_item(CMD_PUTC, 8'h78, 6'd0, 1'b0);
        send_item(CMD_ENDL, 8'h00, 6'd0, 1'b0);
        send_item(CMD_ENDL, 8'h33, 6'd21, 1'b0);
        send_item(CMD_GOTO, 8'h00, 6'd40, 1'b0);
        send_item(CMD_ENDL, 8'h00, 6'd0, 1'b1);
    endtask

    // random items: small alphabet so many puts hit unchanged cells
    task automatic run_random_traffic(int n_items, int idle_pct, int stall_pct);
        cmd_t       c;
        logic [7:0] ch;
        logic [5:0] col;
        logic       ln;
        int         pick;
        int         done;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items)
        begin
            pick = int'($urandom_range(99));
            ch   = 8'($urandom);
            col  = 6'($urandom);
            ln   = 1'($urandom);
            if (pick < 3)
                c = CMD_CLEAR;
            else if (pick < 20)
            begin
                c = CMD_GOTO;
                if ($urandom_range(9) != 0)
                    col = 6'($urandom_range(COLS - 1));
            end
            else if (pick < 90)
            begin
                c = CMD_PUTC;
                if ($urandom_range(1) != 0)
                    ch = ($urandom_range(2) == 0) ? SPACE_CHAR
                                                  : 8'(8'h41 + $urandom_range(2));
            end
            else
                c = CMD_ENDL;
            done++;
            send_item(c, ch, col, ln);
            if ($urandom_range(99) == 0)
                hold_until_drained();
        end
    endtask

    // test sequence
    initial
    begin
        blank_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_clear_and_goto();
        test_put_filtering();
        test_end_of_line();
        run_random_traffic(47, 0, 0);
        run_random_traffic(46, 52, 0);
        run_random_traffic(46, 0, 52);
        run_random_traffic(46, 13, 13);
        hold_until_drained();
        repeat (TAIL) @(posedge clk);
        if (bus_words_due.size() != 0)
        begin
            err_count++;
            $display("%0d words still due at the end", bus_words_due.size());
        end
        $display("covered %0d clear, %0d goto, %0d put, %0d end-of-line; %0d words",
                 kind_count[CMD_CLEAR], kind_count[CMD_GOTO], kind_count[CMD_PUTC],
                 kind_count[CMD_ENDL], words_checked);
        $display("idle mixes: none, sender 52%%, receiver 52%%, both 13%%; %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
